### design/sst_pkg.sv
package sst_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_QUERY  = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_ABSENT   = 3'd2;
    localparam logic [2:0] ST_BADINDEX = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef logic [KEY_WIDTH-1:0] t_key;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [31:0]      key;
        logic [IDX_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic             found;
        logic [31:0]      read_data;
        logic [CNT_W-1:0] count;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_step;
        logic       rd_last;
        logic       rd_slot;
        logic       wr_append;
        logic       wr_move;
        logic       dec_count;
        logic       clr_count;
        logic       finish;
        logic [2:0] res_status;
        logic       res_found;
        logic       res_rdata;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       exhausted;
        logic       full;
        logic       slot_ok;
        logic       pos_last;
        logic       out_free;
    } t_stat;

endpackage

### design/sst_dpath.sv
module sst_dpath
    import sst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    input  logic      i_out_ready,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    t_key             r_mem [CAPACITY];
    logic [2:0]       r_op;
    t_key             r_key;
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_scan_idx;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    t_key             r_rd_data;
    logic             r_out_vld;
    t_out_item        r_out;

    logic [CNT_W-1:0] count_m1;
    logic             scan_more;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_key             wr_data;
    logic [CNT_W-1:0] n_count;

    assign count_m1  = r_count - CNT_W'(1);
    assign scan_more = r_scan_idx < r_count;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_scan_idx[IDX_W-1:0];
        if (i_cmd.scan_step && scan_more) begin
            rd_en = 1'b1;
        end else if (i_cmd.rd_last) begin
            rd_en   = 1'b1;
            rd_addr = count_m1[IDX_W-1:0];
        end else if (i_cmd.rd_slot) begin
            rd_en   = 1'b1;
            rd_addr = r_slot;
        end
    end

    always_comb begin
        wr_en   = i_cmd.wr_append | i_cmd.wr_move;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = r_key;
        if (i_cmd.wr_move) begin
            wr_addr = r_rd_idx;
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_item.opcode;
            r_key  <= i_in_item.key[KEY_WIDTH-1:0];
            r_slot <= i_in_item.slot;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr_count) begin
            n_count = '0;
        end else if (i_cmd.wr_append) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.dec_count) begin
            n_count = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_rd_vld   <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= scan_more;
                if (scan_more) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && scan_more) begin
            r_rd_idx <= r_scan_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.status    <= i_cmd.res_status;
            r_out.found     <= i_cmd.res_found;
            r_out.read_data <= i_cmd.res_rdata ? 32'(r_rd_data) : '0;
            r_out.count     <= r_count;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.hit       = r_rd_vld && (r_rd_data == r_key);
    assign o_stat.exhausted = !r_rd_vld && !scan_more;
    assign o_stat.full      = r_count == CNT_W'(CAPACITY);
    assign o_stat.slot_ok   = CNT_W'(r_slot) < r_count;
    assign o_stat.pos_last  = CNT_W'(r_rd_idx) == count_m1;
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

### design/sst_ctrl.sv
module sst_ctrl
    import sst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_MOVE     = 3'd3;
    localparam logic [2:0] S_RDWAIT   = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] r_res_status;
    logic [2:0] n_res_status;
    logic       r_res_found;
    logic       n_res_found;
    logic       r_res_rdata;
    logic       n_res_rdata;
    t_cmd       cmd;

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_rdata  = r_res_rdata;
        cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_status = ST_OK;
                n_res_found  = 1'b0;
                n_res_rdata  = 1'b0;
                n_state      = S_FINISH;
                case (i_stat.op)
                    OP_QUERY, OP_ADD, OP_REMOVE: begin
                        cmd.scan_start = 1'b1;
                        n_state        = S_SCAN;
                    end
                    OP_READ: begin
                        if (i_stat.slot_ok) begin
                            cmd.rd_slot = 1'b1;
                            n_state     = S_RDWAIT;
                        end else begin
                            n_res_status = ST_BADINDEX;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clr_count = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_FINISH;
                    case (i_stat.op)
                        OP_QUERY: n_res_found = 1'b1;
                        OP_ADD:   n_res_status = ST_PRESENT;
                        default: begin
                            if (i_stat.pos_last) begin
                                cmd.dec_count = 1'b1;
                            end else begin
                                cmd.rd_last = 1'b1;
                                n_state     = S_MOVE;
                            end
                        end
                    endcase
                end else if (i_stat.exhausted) begin
                    n_state = S_FINISH;
                    case (i_stat.op)
                        OP_QUERY: n_res_found = 1'b0;
                        OP_ADD: begin
                            if (i_stat.full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                cmd.wr_append = 1'b1;
                            end
                        end
                        default: n_res_status = ST_ABSENT;
                    endcase
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MOVE: begin
                cmd.wr_move   = 1'b1;
                cmd.dec_count = 1'b1;
                n_state       = S_FINISH;
            end
            S_RDWAIT: begin
                n_res_rdata = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        cmd.res_status = r_res_status;
        cmd.res_found  = r_res_found;
        cmd.res_rdata  = r_res_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_rdata  <= n_res_rdata;
    end

    assign o_in_ready = r_state == S_IDLE;
    assign o_cmd      = cmd;

endmodule

### design/small_set_table.sv
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_in_item  (opcode, key, slot)
// out      output     o_out_valid / i_out_ready  o_out_item (status, found, read_data, count)
//
// One item at a time. Query, add and remove scan the stored keys through the single
// memory read port, one entry a cycle, until a hit or the end of the held entries. On a
// remove hit that is not the last entry, the last entry is moved into the freed place.
// Read fetches its slot's entry; bad index reads, clear and unused opcodes use no read.
// Reset empties the set at once; no clearing pass.
// A held result does not block the next item from being accepted; that item waits in its
// last cycle until the output register is free.
module small_set_table
    import sst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd  cmd;
    t_stat stat;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sst_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.count <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.scan_step, cmd.rd_last, cmd.rd_slot}))
        else $error("read port conflict");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_append, cmd.wr_move, cmd.clr_count}))
        else $error("write or count update conflict");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready while item in work");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.found) |-> (o_out_item.status == ST_OK))
        else $error("found with bad status");

endmodule
